FILE: src/btr_pkg.sv
// Package for the byte transliterator: item types, codes and scan token.
package btr_pkg;

  localparam int MAX_CHARS_DEF = 256;

  typedef enum logic [2:0] {
    OP_SRC_CHAR  = 3'd0,
    OP_SRC_MARK  = 3'd1,
    OP_SRC_FIN   = 3'd2,
    OP_TGT_CHAR  = 3'd3,
    OP_TGT_MARK  = 3'd4,
    OP_TGT_FIN   = 3'd5,
    OP_TRANSLATE = 3'd6,
    OP_CLEAR     = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_NO_START = 3'd1,
    STAT_REVERSED = 3'd2,
    STAT_DANGLING = 3'd3,
    STAT_FULL     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] byte_value;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
  } out_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] key;
    logic       found;
    logic       hit_tgt;
    logic [7:0] hit_byte;
    logic [7:0] last_s;
    logic [7:0] last_t;
  } tok_t;

  typedef struct packed {
    logic       src_we;
    logic       tgt_we;
    logic [7:0] data;
  } wr_t;

endpackage

FILE: src/byte_transliterator_core.sv
// Top level of the byte transliterator: sequencer, counters and result register.
// One item is in work at a time. Character, mark, finish and clear items write the
// result register at the transfer. A translate item, and a character item that
// closes a range, send a token down the row of MAX_CHARS cells, one cell per cycle;
// the result is registered when the token leaves the last cell or, for a range, once
// the fill state has written each byte from its start to its end. A new item is
// taken as soon as the previous result has moved to the output register.
module byte_transliterator_core #(
  parameter int MAX_CHARS = btr_pkg::MAX_CHARS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  btr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output btr_pkg::out_t out_data
);

  localparam int AW = $clog2(MAX_CHARS);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_CHARS);

  btr_pkg::state_e state_r, state_nxt;
  logic [CW-1:0]   scnt_r, scnt_nxt;
  logic [CW-1:0]   tcnt_r, tcnt_nxt;
  logic            spend_r, spend_nxt;
  logic            tpend_r, tpend_nxt;
  logic            out_valid_r, out_valid_nxt;
  btr_pkg::out_t   out_data_r, out_data_nxt;
  btr_pkg::op_e    op_r, op_nxt;
  logic [7:0]      b_r, b_nxt;
  logic [7:0]      v_r, v_nxt;
  logic            drop_r, drop_nxt;
  btr_pkg::out_t   res_r, res_nxt;

  btr_pkg::wr_t    wr;
  logic [AW-1:0]   wr_addr;
  btr_pkg::tok_t   tok_in;
  btr_pkg::tok_t   tok_out;

  logic            accept;
  logic            out_free;
  logic            need_scan;
  logic            is_src;
  logic [7:0]      first;
  logic [CW-1:0]   cnt;

  assign in_stall  = state_r != btr_pkg::ST_IDLE;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    need_scan = (in_data.op == btr_pkg::OP_TRANSLATE) ||
                ((in_data.op == btr_pkg::OP_SRC_CHAR) && spend_r && (scnt_r != '0)) ||
                ((in_data.op == btr_pkg::OP_TGT_CHAR) && tpend_r && (tcnt_r != '0));
    is_src    = op_r == btr_pkg::OP_SRC_CHAR;
    first     = is_src ? tok_out.last_s : tok_out.last_t;
    cnt       = is_src ? scnt_r : tcnt_r;
  end

  always_comb begin
    tok_in          = '0;
    tok_in.valid    = accept && need_scan;
    tok_in.key      = in_data.byte_value;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      btr_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = need_scan ? btr_pkg::ST_SCAN : btr_pkg::ST_EMIT;
        end
      end
      btr_pkg::ST_SCAN: begin
        if (tok_out.valid) begin
          if ((op_r == btr_pkg::OP_TRANSLATE) || (first > b_r)) begin
            state_nxt = btr_pkg::ST_EMIT;
          end else begin
            state_nxt = btr_pkg::ST_FILL;
          end
        end
      end
      btr_pkg::ST_FILL: begin
        if (v_r == b_r) begin
          state_nxt = btr_pkg::ST_EMIT;
        end
      end
      btr_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = btr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = btr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    scnt_nxt      = scnt_r;
    tcnt_nxt      = tcnt_r;
    spend_nxt     = spend_r;
    tpend_nxt     = tpend_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    op_nxt        = op_r;
    b_nxt         = b_r;
    v_nxt         = v_r;
    drop_nxt      = drop_r;
    res_nxt       = res_r;
    wr            = '0;
    wr_addr       = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      btr_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt          = in_data.op;
          b_nxt           = in_data.byte_value;
          res_nxt         = '0;
          res_nxt.status  = btr_pkg::STAT_OK;
          case (in_data.op)
            btr_pkg::OP_SRC_CHAR: begin
              if (!spend_r) begin
                if (scnt_r < MAX_C) begin
                  wr.src_we = 1'b1;
                  wr.data   = in_data.byte_value;
                  wr_addr   = scnt_r[AW-1:0];
                  scnt_nxt  = scnt_r + 1'b1;
                end else begin
                  res_nxt.status = btr_pkg::STAT_FULL;
                end
              end else begin
                spend_nxt = 1'b0;
                if (scnt_r == '0) begin
                  res_nxt.status = btr_pkg::STAT_NO_START;
                end
              end
            end
            btr_pkg::OP_SRC_MARK: spend_nxt = 1'b1;
            btr_pkg::OP_SRC_FIN: begin
              res_nxt.status = spend_r ? btr_pkg::STAT_DANGLING : btr_pkg::STAT_OK;
              spend_nxt      = 1'b0;
            end
            btr_pkg::OP_TGT_CHAR: begin
              if (!tpend_r) begin
                if (tcnt_r < MAX_C) begin
                  wr.tgt_we = 1'b1;
                  wr.data   = in_data.byte_value;
                  wr_addr   = tcnt_r[AW-1:0];
                  tcnt_nxt  = tcnt_r + 1'b1;
                end else begin
                  res_nxt.status = btr_pkg::STAT_FULL;
                end
              end else begin
                tpend_nxt = 1'b0;
                if (tcnt_r == '0) begin
                  res_nxt.status = btr_pkg::STAT_NO_START;
                end
              end
            end
            btr_pkg::OP_TGT_MARK: tpend_nxt = 1'b1;
            btr_pkg::OP_TGT_FIN: begin
              res_nxt.status = tpend_r ? btr_pkg::STAT_DANGLING : btr_pkg::STAT_OK;
              tpend_nxt      = 1'b0;
            end
            btr_pkg::OP_TRANSLATE: begin
            end
            btr_pkg::OP_CLEAR: begin
              scnt_nxt  = '0;
              tcnt_nxt  = '0;
              spend_nxt = 1'b0;
              tpend_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      btr_pkg::ST_SCAN: begin
        if (tok_out.valid) begin
          if (op_r == btr_pkg::OP_TRANSLATE) begin
            if ((tcnt_r == '0) || ((b_r != 8'd0) && !tok_out.found)) begin
              res_nxt.out_byte = b_r;
            end else if (tok_out.found && tok_out.hit_tgt) begin
              res_nxt.out_byte = tok_out.hit_byte;
            end else begin
              res_nxt.out_byte = tok_out.last_t;
            end
          end else begin
            if (is_src) begin
              scnt_nxt = scnt_r - 1'b1;
            end else begin
              tcnt_nxt = tcnt_r - 1'b1;
            end
            if (first > b_r) begin
              res_nxt.status = btr_pkg::STAT_REVERSED;
            end else begin
              v_nxt    = first;
              drop_nxt = 1'b0;
            end
          end
        end
      end
      btr_pkg::ST_FILL: begin
        if (cnt < MAX_C) begin
          wr.src_we = is_src;
          wr.tgt_we = !is_src;
          wr.data   = v_r;
          wr_addr   = cnt[AW-1:0];
          if (is_src) begin
            scnt_nxt = scnt_r + 1'b1;
          end else begin
            tcnt_nxt = tcnt_r + 1'b1;
          end
        end else begin
          drop_nxt = 1'b1;
        end
        v_nxt = v_r + 1'b1;
        if (v_r == b_r) begin
          res_nxt.status = (drop_r || (cnt >= MAX_C)) ? btr_pkg::STAT_FULL
                                                      : btr_pkg::STAT_OK;
        end
      end
      btr_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= btr_pkg::ST_IDLE;
      scnt_r      <= '0;
      tcnt_r      <= '0;
      spend_r     <= 1'b0;
      tpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scnt_r      <= scnt_nxt;
      tcnt_r      <= tcnt_nxt;
      spend_r     <= spend_nxt;
      tpend_r     <= tpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    op_r       <= op_nxt;
    b_r        <= b_nxt;
    v_r        <= v_nxt;
    drop_r     <= drop_nxt;
    res_r      <= res_nxt;
  end

  btr_chain #(
    .MAX_CHARS (MAX_CHARS)
  ) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .wr_addr (wr_addr),
    .scount  (scnt_r),
    .tcount  (tcnt_r),
    .tok_in  (tok_in),
    .tok_out (tok_out)
  );

endmodule

FILE: src/btr_cell.sv
// One cell of the list chain: one source byte, one target byte, one token stage.
module btr_cell #(
  parameter int MAX_CHARS = btr_pkg::MAX_CHARS_DEF,
  parameter int IDX       = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  btr_pkg::wr_t                   wr,
  input  logic [$clog2(MAX_CHARS)-1:0]   wr_addr,
  input  logic [$clog2(MAX_CHARS):0]     scount,
  input  logic [$clog2(MAX_CHARS):0]     tcount,
  input  btr_pkg::tok_t                  tok_in,
  output btr_pkg::tok_t                  tok_out
);

  localparam int AW = $clog2(MAX_CHARS);
  localparam int CW = AW + 1;
  localparam logic [AW-1:0] IDX_A  = AW'(IDX);
  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] IDX_C1 = CW'(IDX + 1);

  logic [7:0]    s_r;
  logic [7:0]    t_r;
  btr_pkg::tok_t tok_r;
  btr_pkg::tok_t tok_nxt;
  logic          in_src;
  logic          in_tgt;
  logic          hit;

  always_comb begin
    in_src  = IDX_C < scount;
    in_tgt  = IDX_C < tcount;
    hit     = !tok_in.found &&
              ((tok_in.key != 8'd0) ? (in_src && (s_r == tok_in.key)) : (IDX_C == scount));
    tok_nxt = tok_in;
    if (hit) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.hit_tgt  = in_tgt;
      tok_nxt.hit_byte = t_r;
    end
    if (IDX_C1 == scount) begin
      tok_nxt.last_s = s_r;
    end
    if (IDX_C1 == tcount) begin
      tok_nxt.last_t = t_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.src_we && (wr_addr == IDX_A)) begin
      s_r <= wr.data;
    end
    if (wr.tgt_we && (wr_addr == IDX_A)) begin
      t_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

FILE: src/btr_chain.sv
// Row of list cells that a scan token walks one cell per cycle.
module btr_chain #(
  parameter int MAX_CHARS = btr_pkg::MAX_CHARS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  btr_pkg::wr_t                   wr,
  input  logic [$clog2(MAX_CHARS)-1:0]   wr_addr,
  input  logic [$clog2(MAX_CHARS):0]     scount,
  input  logic [$clog2(MAX_CHARS):0]     tcount,
  input  btr_pkg::tok_t                  tok_in,
  output btr_pkg::tok_t                  tok_out
);

  btr_pkg::tok_t tok_w [MAX_CHARS+1];

  assign tok_w[0] = tok_in;

  for (genvar i = 0; i < MAX_CHARS; i++) begin : g_cell
    btr_cell #(
      .MAX_CHARS (MAX_CHARS),
      .IDX       (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr),
      .wr_addr (wr_addr),
      .scount  (scount),
      .tcount  (tcount),
      .tok_in  (tok_w[i]),
      .tok_out (tok_w[i+1])
    );
  end

  assign tok_out = tok_w[MAX_CHARS];

endmodule
